// ===== rtl/core/hte_pkg.sv =====
`default_nettype none

package hte_pkg;

	localparam int MAX_CODE_LEN_DEF  = 24;
	localparam int ALPHABET_SIZE_DEF = 256;

	localparam int SYMBOL_W     = 8;
	localparam int CODE_FIELD_W = 24;
	localparam int LEN_W        = 5;
	localparam int PEND_W       = 7;
	localparam int ACC_W        = 32;
	localparam int BYTE_W       = 8;
	localparam int PAD_W        = 3;
	localparam int MAX_RESULTS  = 3;
	localparam int QUEUE_DEPTH  = 4;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_value;
		logic [PAD_W-1:0]  pad_bits;
		logic              no_code;
		logic              last;
	} res_t;

	typedef struct packed {
		logic                      valid;
		logic [1:0]                count;
		res_t [MAX_RESULTS-1:0]    res;
	} push_t;

endpackage

`default_nettype wire

// ===== rtl/core/hte_code_table.sv =====
`default_nettype none

module hte_code_table #(
	parameter int ALPHABET_SIZE = hte_pkg::ALPHABET_SIZE_DEF,
	parameter int CODE_W        = hte_pkg::CODE_FIELD_W
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  rd_en,
	input  wire logic                                  wr_en,
	input  wire logic [$clog2(ALPHABET_SIZE)-1:0]      addr,
	input  wire logic [hte_pkg::CODE_FIELD_W-1:0]      wr_bits,
	input  wire logic [hte_pkg::LEN_W-1:0]             wr_len,
	output logic      [hte_pkg::LEN_W-1:0]             rd_len,
	output logic      [CODE_W-1:0]                     rd_code
);

	localparam logic [hte_pkg::LEN_W-1:0] CAP = hte_pkg::LEN_W'(CODE_W);

	logic [hte_pkg::LEN_W+CODE_W-1:0] mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0]         vld_q;
	logic [hte_pkg::LEN_W+CODE_W-1:0] rd_data_s1;
	logic                             rd_vld_s1;

	logic [hte_pkg::LEN_W-1:0]        len_c;
	logic [hte_pkg::CODE_FIELD_W-1:0] masked;
	logic [hte_pkg::CODE_FIELD_W-1:0] aligned;

	// clamp length, drop bits above it, left-align the code
	always_comb begin
		len_c   = (wr_len > CAP) ? CAP : wr_len;
		masked  = wr_bits & ~({hte_pkg::CODE_FIELD_W{1'b1}} << len_c);
		aligned = masked << (CAP - len_c);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= {len_c, aligned[CODE_W-1:0]};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= vld_q[addr];
			end
		end
	end

	// entries never loaded read as no code
	assign rd_len  = rd_vld_s1 ? rd_data_s1[hte_pkg::LEN_W+CODE_W-1:CODE_W] : '0;
	assign rd_code = rd_data_s1[CODE_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/hte_bit_packer.sv =====
`default_nettype none

module hte_bit_packer #(
	parameter int CODE_W = hte_pkg::CODE_FIELD_W
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_accept,
	input  wire logic [1:0]                in_op,
	input  wire logic                      in_alpha,
	input  wire logic [hte_pkg::LEN_W-1:0] rd_len,
	input  wire logic [CODE_W-1:0]         rd_code,
	input  wire logic                      space_ok,
	output logic                           ready,
	output hte_pkg::push_t                 push
);

	localparam int ACC_W  = hte_pkg::ACC_W;
	localparam int PEND_W = hte_pkg::PEND_W;

	logic                        vld_s1;
	hte_pkg::op_t                op_s1;
	logic                        alpha_s1;
	logic [PEND_W-1:0]           pend_q;
	logic [2:0]                  cnt_q;

	logic                        fire;
	logic [hte_pkg::LEN_W-1:0]   total;
	logic [1:0]                  n_enc;
	logic [ACC_W-1:0]            comb;
	logic [ACC_W-1:0]            shifted;
	logic [PEND_W-1:0]           pend_d;
	logic [2:0]                  cnt_d;

	assign fire  = vld_s1 && space_ok;
	assign ready = !vld_s1 || fire;

	// accumulator is left-aligned: earliest bit at the top
	always_comb begin
		total   = hte_pkg::LEN_W'({2'b00, cnt_q}) + rd_len;
		n_enc   = total[4:3];
		comb    = {pend_q, {(ACC_W-PEND_W){1'b0}}}
			| ({rd_code, {(ACC_W-CODE_W){1'b0}}} >> cnt_q);
		shifted = comb << {n_enc, 3'b000};
	end

	always_comb begin
		push        = '0;
		push.valid  = vld_s1;
		pend_d      = pend_q;
		cnt_d       = cnt_q;
		unique case (op_s1)
			hte_pkg::OP_ENCODE: begin
				if (!alpha_s1 || rd_len == '0) begin
					push.count          = 2'd1;
					push.res[0].no_code = 1'b1;
					push.res[0].last    = 1'b1;
				end else begin
					push.count = n_enc;
					for (int k = 0; k < hte_pkg::MAX_RESULTS; k++) begin
						push.res[k].byte_value = comb[ACC_W-1-8*k -: 8];
						push.res[k].last       = (2'(k) == n_enc - 2'd1);
					end
					pend_d = shifted[ACC_W-1 -: PEND_W];
					cnt_d  = total[2:0];
				end
			end
			hte_pkg::OP_FLUSH: begin
				if (cnt_q != '0) begin
					push.count             = 2'd1;
					push.res[0].byte_value = {pend_q, 1'b0};
					push.res[0].pad_bits   = 3'(4'd8 - {1'b0, cnt_q});
					push.res[0].last       = 1'b1;
					pend_d                 = '0;
					cnt_d                  = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1    <= hte_pkg::op_t'(in_op);
			alpha_s1 <= in_alpha;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			pend_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (in_accept) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (fire) begin
				pend_q <= pend_d;
				cnt_q  <= cnt_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/hte_out_queue.sv =====
`default_nettype none

module hte_out_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire hte_pkg::push_t  push,
	output logic                 space_ok,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output hte_pkg::res_t        out_res
);

	localparam int DEPTH = hte_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);

	hte_pkg::res_t  buf_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [PW:0]    cnt_q;
	logic           do_push;
	logic           pop;

	assign space_ok  = (cnt_q + (PW+1)'(push.count)) <= (PW+1)'(DEPTH);
	assign do_push   = push.valid && space_ok;
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign out_res   = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			for (int k = 0; k < hte_pkg::MAX_RESULTS; k++) begin
				if (2'(k) < push.count) begin
					buf_q[wr_ptr_q + PW'(k)] <= push.res[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(push.count);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (do_push ? (PW+1)'(push.count) : '0) - (PW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/huffman_table_encoder.sv =====
`default_nettype none

// Huffman encoder with a loaded code table. Every transaction on the slave side is
// one item: load writes a symbol's code into the table, encode appends a symbol's code
// to the bit accumulator and sends each completed byte (or one no_code transaction if
// the symbol has no code), flush pads and sends the partial byte with tlast. One item
// is accepted per cycle; an encode gives zero to three output transactions, which pass
// through a four-entry output queue, so the input stalls only while that queue lacks
// room for the item in the lookup stage. The code table read is registered; packing
// is combinational and writes straight into the output queue. The table is one memory
// with a single address port: every item reads it, a load also writes it. Per-entry
// valid bits make it read as empty right after reset, with no clearing pass.

module huffman_table_encoder #(
	parameter int MAX_CODE_LEN  = hte_pkg::MAX_CODE_LEN_DEF,
	parameter int ALPHABET_SIZE = hte_pkg::ALPHABET_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // symbol, code_bits, code_length
	input  wire logic [1:0]  s_tuser,   // operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata,   // byte_value, pad_bits
	output logic             m_tuser,   // no_code
	output logic             m_tlast
);

	localparam int CODE_W = (MAX_CODE_LEN < hte_pkg::CODE_FIELD_W) ?
		MAX_CODE_LEN : hte_pkg::CODE_FIELD_W;
	localparam int AW = $clog2(ALPHABET_SIZE);

	logic [hte_pkg::SYMBOL_W-1:0]     symbol;
	logic [hte_pkg::CODE_FIELD_W-1:0] code_bits;
	logic [hte_pkg::LEN_W-1:0]        code_length;
	logic                             in_accept;
	logic                             in_alpha;
	logic                             wr_en;
	logic [hte_pkg::LEN_W-1:0]        rd_len;
	logic [CODE_W-1:0]                rd_code;
	logic                             space_ok;
	hte_pkg::push_t                   push;
	hte_pkg::res_t                    out_res;

	assign symbol      = s_tdata[7:0];
	assign code_bits   = s_tdata[31:8];
	assign code_length = s_tdata[36:32];

	assign in_accept = s_tvalid && s_tready;
	assign in_alpha  = {1'b0, symbol} < 9'(ALPHABET_SIZE);
	assign wr_en     = in_accept && in_alpha && (s_tuser == hte_pkg::OP_LOAD);

	hte_code_table #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.CODE_W        (CODE_W)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_accept),
		.wr_en   (wr_en),
		.addr    (symbol[AW-1:0]),
		.wr_bits (code_bits),
		.wr_len  (code_length),
		.rd_len  (rd_len),
		.rd_code (rd_code)
	);

	hte_bit_packer #(
		.CODE_W (CODE_W)
	) u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_op     (s_tuser),
		.in_alpha  (in_alpha),
		.rd_len    (rd_len),
		.rd_code   (rd_code),
		.space_ok  (space_ok),
		.ready     (s_tready),
		.push      (push)
	);

	hte_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {5'b00000, out_res.pad_bits, out_res.byte_value};
	assign m_tuser = out_res.no_code;
	assign m_tlast = out_res.last;

endmodule

`default_nettype wire

// ===== sim/huffman_table_encoder_tb.sv =====
`timescale 1ns / 100ps

module huffman_table_encoder_tb;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CLOCK_LIMIT = 100000;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_ITEMS = 105;
	localparam int DRAIN_CYCLES = 40;
	localparam int CODE_CAP = (hte_pkg::MAX_CODE_LEN_DEF < hte_pkg::CODE_FIELD_W) ?
		hte_pkg::MAX_CODE_LEN_DEF : hte_pkg::CODE_FIELD_W;
	localparam hte_pkg::res_t NO_RES = '0;
	localparam hte_pkg::res_t NO_CODE_RES =
		'{byte_value: 8'h00, pad_bits: 3'd0, no_code: 1'b1, last: 1'b1};
	localparam hte_pkg::res_t ONE_BIT_FLUSH =
		'{byte_value: 8'h80, pad_bits: 3'd7, no_code: 1'b0, last: 1'b1};

	typedef struct {
		logic [1:0]     op;
		logic [7:0]     sym;
		logic [23:0]    bits;
		logic [4:0]     len;
		bit             typed;
		int             n_typed;
		hte_pkg::res_t  typed_res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	logic [23:0] code_val [hte_pkg::ALPHABET_SIZE_DEF];
	logic [4:0]  code_len [hte_pkg::ALPHABET_SIZE_DEF];
	logic [6:0]  acc_bits;
	logic [2:0]  acc_count;

	hte_pkg::res_t awaited_bytes [$];
	int   loaded_syms [$];
	int   mismatches = 0;
	int   cycle_count = 0;
	int   send_calm = 0;
	int   recv_calm = 0;
	bit   hold_req = 1'b0;
	bit   hold_done = 1'b0;

	stim_row_t directed [25] = '{
		'{hte_pkg::OP_ENCODE, 8'd0,   24'h000000, 5'd0,  1'b1, 1, NO_CODE_RES},
		'{hte_pkg::OP_FLUSH,  8'd0,   24'h000000, 5'd0,  1'b1, 0, NO_RES},
		'{OP_UNUSED,          8'h5A,  24'hFFFFFF, 5'd31, 1'b1, 0, NO_RES},
		'{hte_pkg::OP_LOAD,   8'd255, 24'hFFFFFF, 5'd24, 1'b1, 0, NO_RES},
		'{hte_pkg::OP_ENCODE, 8'd255, 24'h000000, 5'd0,  1'b0, 0, NO_RES},
		'{hte_pkg::OP_LOAD,   8'd0,   24'h000001, 5'd1,  1'b1, 0, NO_RES},
		'{hte_pkg::OP_ENCODE, 8'd0,   24'h000000, 5'd0,  1'b1, 0, NO_RES},
		'{hte_pkg::OP_FLUSH,  8'd0,   24'h000000, 5'd0,  1'b1, 1, ONE_BIT_FLUSH},
		'{hte_pkg::OP_LOAD,   8'd1,   24'hFFFFFF, 5'd31, 1'b1, 0, NO_RES},
		'{hte_pkg::OP_ENCODE, 8'd1,   24'h000000, 5'd0,  1'b0, 0, NO_RES},
		'{hte_pkg::OP_LOAD,   8'd2,   24'hABCDEF, 5'd3,  1'b1, 0, NO_RES},
		'{hte_pkg::OP_ENCODE, 8'd2,   24'h000000, 5'd0,  1'b1, 0, NO_RES},
		'{hte_pkg::OP_ENCODE, 8'd0,   24'h000000, 5'd0,  1'b1, 0, NO_RES},
		'{hte_pkg::OP_ENCODE, 8'd255, 24'h000000, 5'd0,  1'b0, 0, NO_RES},
		'{hte_pkg::OP_FLUSH,  8'd0,   24'h000000, 5'd0,  1'b0, 0, NO_RES},
		'{hte_pkg::OP_LOAD,   8'd3,   24'h000055, 5'd7,  1'b1, 0, NO_RES},
		'{hte_pkg::OP_ENCODE, 8'd3,   24'h000000, 5'd0,  1'b1, 0, NO_RES},
		'{hte_pkg::OP_ENCODE, 8'd3,   24'h000000, 5'd0,  1'b0, 0, NO_RES},
		'{hte_pkg::OP_LOAD,   8'd255, 24'h000000, 5'd0,  1'b1, 0, NO_RES},
		'{hte_pkg::OP_ENCODE, 8'd255, 24'h000000, 5'd0,  1'b1, 1, NO_CODE_RES},
		'{hte_pkg::OP_LOAD,   8'd4,   24'h000000, 5'd8,  1'b1, 0, NO_RES},
		'{hte_pkg::OP_ENCODE, 8'd4,   24'h000000, 5'd0,  1'b0, 0, NO_RES},
		'{hte_pkg::OP_FLUSH,  8'd0,   24'h000000, 5'd0,  1'b0, 0, NO_RES},
		'{hte_pkg::OP_LOAD,   8'd128, 24'h800000, 5'd24, 1'b1, 0, NO_RES},
		'{hte_pkg::OP_ENCODE, 8'd128, 24'h000000, 5'd0,  1'b0, 0, NO_RES}
	};

	huffman_table_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CLOCK_LIMIT) begin
			$display("[huffman_table_encoder] ERROR");
			$finish;
		end
	end

	function automatic int draw_gap(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0)
			calm = $urandom_range(5, 20);
		return $urandom_range(0, 13);
	endfunction

	function automatic void predict_packed_bytes(input logic [1:0] op, input logic [7:0] sym,
			input logic [23:0] bits, input logic [4:0] len, ref hte_pkg::res_t outs [$]);
		logic [63:0]   acc;
		int            clen;
		int            total;
		int            pad;
		hte_pkg::res_t r;
		outs.delete();
		case (op)
			hte_pkg::OP_LOAD: begin
				clen = (len > CODE_CAP) ? CODE_CAP : len;
				code_len[sym] = clen[4:0];
				code_val[sym] = bits & ((24'h1 << clen) - 24'h1);
				if (clen == CODE_CAP)
					code_val[sym] = bits;
			end
			hte_pkg::OP_ENCODE: begin
				clen = code_len[sym];
				if (clen == 0) begin
					outs.push_back(NO_CODE_RES);
				end else begin
					acc = ({57'b0, acc_bits} << clen) | {40'b0, code_val[sym]};
					total = acc_count + clen;
					while (total >= 8 && outs.size() < hte_pkg::MAX_RESULTS) begin
						r = NO_RES;
						r.byte_value = acc[total-1 -: 8];
						outs.push_back(r);
						total -= 8;
					end
					acc_count = total[2:0];
					acc_bits = acc[6:0] & ((7'h1 << total) - 7'h1);
					if (outs.size() > 0)
						outs[outs.size()-1].last = 1'b1;
				end
			end
			hte_pkg::OP_FLUSH: begin
				if (acc_count != 0) begin
					pad = 8 - acc_count;
					r.byte_value = {1'b0, acc_bits} << pad;
					r.pad_bits = pad[2:0];
					r.no_code = 1'b0;
					r.last = 1'b1;
					outs.push_back(r);
					acc_bits = '0;
					acc_count = '0;
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(input stim_row_t row);
		int            gap;
		hte_pkg::res_t outs [$];
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b0, row.len, row.bits, row.sym};
		s_tuser <= row.op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_packed_bytes(row.op, row.sym, row.bits, row.len, outs);
		if (row.typed) begin
			if (row.n_typed > 0)
				awaited_bytes.push_back(row.typed_res);
		end else begin
			foreach (outs[k])
				awaited_bytes.push_back(outs[k]);
		end
		@(negedge clk);
	endtask

	// check each output transaction against the oldest expected byte
	initial begin
		hte_pkg::res_t exp_res;
		int            gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				gap = draw_gap(recv_calm);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			if (awaited_bytes.size() == 0) begin
				$error("unexpected output: byte_value %0h pad_bits %0d no_code %0b last %0b",
					m_tdata[7:0], m_tdata[10:8], m_tuser, m_tlast);
				mismatches++;
			end else begin
				exp_res = awaited_bytes.pop_front();
				if (m_tdata[7:0] !== exp_res.byte_value) begin
					$error("byte_value: expected %0h, actual %0h", exp_res.byte_value, m_tdata[7:0]);
					mismatches++;
				end
				if (m_tdata[10:8] !== exp_res.pad_bits) begin
					$error("pad_bits: expected %0d, actual %0d", exp_res.pad_bits, m_tdata[10:8]);
					mismatches++;
				end
				if (m_tuser !== exp_res.no_code) begin
					$error("no_code: expected %0b, actual %0b", exp_res.no_code, m_tuser);
					mismatches++;
				end
				if (m_tlast !== exp_res.last) begin
					$error("last: expected %0b, actual %0b", exp_res.last, m_tlast);
					mismatches++;
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		stim_row_t row;
		int        sent;
		int        pick;
		int        len_kind;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		acc_bits = '0;
		acc_count = '0;
		foreach (code_len[k]) begin
			code_len[k] = '0;
			code_val[k] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[k]) begin
			if (directed[k].op == hte_pkg::OP_LOAD)
				loaded_syms.push_back(int'(directed[k].sym));
			send_item(directed[k]);
		end

		// random items, starting back-to-back, while the output side holds off
		send_calm = 24;
		hold_req = 1'b1;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 25)
				row.op = hte_pkg::OP_LOAD;
			else if (pick < 85)
				row.op = hte_pkg::OP_ENCODE;
			else if (pick < 95)
				row.op = hte_pkg::OP_FLUSH;
			else
				row.op = OP_UNUSED;
			if (row.op == hte_pkg::OP_ENCODE && $urandom_range(0, 4) != 0)
				row.sym = 8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
			else
				row.sym = 8'($urandom_range(0, 255));
			row.bits = 24'($urandom());
			len_kind = $urandom_range(0, 9);
			if (len_kind == 0)
				row.len = '0;
			else if (len_kind == 1)
				row.len = 5'($urandom_range(CODE_CAP + 1, 31));
			else
				row.len = 5'($urandom_range(1, CODE_CAP));
			row.typed = 1'b0;
			row.n_typed = 0;
			row.typed_res = NO_RES;
			if (row.op == hte_pkg::OP_LOAD)
				loaded_syms.push_back(int'(row.sym));
			if (row.op != OP_UNUSED)
				sent++;
			send_item(row);
		end
		s_tvalid <= 1'b0;

		while (awaited_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[huffman_table_encoder] OK");
		else
			$display("[huffman_table_encoder] ERROR");
		$finish;
	end

endmodule
